// ===== hdl/lbs_pkg.sv =====
`default_nettype none
package lbs_pkg;

   localparam int JOINTS      = 64;
   localparam int INFL        = 4;
   localparam int WORDS       = 12;
   localparam int STORE_DEPTH = JOINTS * WORDS;
   localparam int JOINT_AW    = (JOINTS > 1) ? $clog2(JOINTS) : 1;
   localparam int INFL_W      = (INFL > 1) ? $clog2(INFL) : 1;

   // accumulator holds determinant and numerators (three 32x65 products)
   localparam int ACC_W = 100;
   localparam int NUM_W = ACC_W + 16;
   localparam int DS_W  = ACC_W + 33;

   localparam int COFS       = 9;
   localparam int ROWS       = 3;
   localparam int POS_TERMS  = 4;
   localparam int MAC_DRAIN  = 2;
   localparam int LANE_DRAIN = 2;
   localparam int Q16_ONE    = 65536;

   // floor(a / 12) = (a * 683) >> 13 for any 10-bit a
   localparam int RECIP12  = 683;
   localparam int RECIP_SH = 13;

   typedef enum logic [2:0] {
      OP_LOAD  = 3'd0,
      OP_START = 3'd1,
      OP_ADD   = 3'd2,
      OP_POS   = 3'd3,
      OP_DIR   = 3'd4
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INF,
      ST_INF_WAIT,
      ST_POS,
      ST_COF,
      ST_DET,
      ST_NUM,
      ST_DRAIN,
      ST_CHECK,
      ST_DIV,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_CHECK,
      DV_RUN,
      DV_ROUND
   } div_state_type;

   typedef enum logic [2:0] {
      DST_NONE,
      DST_COF,
      DST_DET,
      DST_NUM,
      DST_POS
   } dest_type;

   // cofactor k = A0*B0 - A1*B1, entries are row*4+col of the blended matrix
   localparam logic [3:0] COF_TAB [COFS][4] = '{
      '{4'd5,  4'd10, 4'd6,  4'd9},
      '{4'd6,  4'd8,  4'd4,  4'd10},
      '{4'd4,  4'd9,  4'd5,  4'd8},
      '{4'd9,  4'd2,  4'd10, 4'd1},
      '{4'd10, 4'd0,  4'd8,  4'd2},
      '{4'd8,  4'd1,  4'd9,  4'd0},
      '{4'd1,  4'd6,  4'd2,  4'd5},
      '{4'd2,  4'd4,  4'd0,  4'd6},
      '{4'd0,  4'd5,  4'd1,  4'd4}
   };

   typedef struct packed {
      logic                clear;
      logic [JOINT_AW-1:0] wr_addr;
      logic [31:0]         wr_data;
      logic                rd_en;
      logic [JOINT_AW-1:0] rd_addr;
      logic [15:0]         weight;
   } lane_ctl_type;

   typedef struct packed {
      logic               valid;
      logic signed [32:0] a;
      logic signed [32:0] b;
      logic               shift_hi;
      logic               neg;
      logic               first;
      logic               last;
      dest_type           dest;
      logic [3:0]         idx;
   } mac_op_type;

   typedef struct packed {
      logic       valid;
      dest_type   dest;
      logic [3:0] idx;
   } mac_done_type;

endpackage
`default_nettype wire

// ===== hdl/lbs_lane.sv =====
`default_nettype none
module lbs_lane (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lbs_pkg::lane_ctl_type ctl,
   input  wire logic                 we,
   output logic signed [31:0]        blend
);

   localparam logic signed [33:0] P_MAX = 34'sh7fffffff;
   localparam logic signed [33:0] P_MIN = ~P_MAX;

   logic [31:0]        bank_mem [lbs_pkg::JOINTS];
   logic [31:0]        rd_data_ff;
   logic [15:0]        w1_ff;
   logic               rd_v_ff;
   logic signed [48:0] prod_ff, prod_in;
   logic               pv_ff;
   logic signed [31:0] blend_ff, blend_in;

   logic signed [48:0] bias, rnd;
   logic signed [33:0] part;
   logic signed [31:0] part32;
   logic signed [32:0] sum;

   always_ff @(posedge clock) begin
      if (we) begin
         bank_mem[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= bank_mem[ctl.rd_addr];
      end
      w1_ff   <= ctl.weight;
      prod_ff <= prod_in;
   end

   always_comb begin
      prod_in = 49'($signed(rd_data_ff) * $signed({1'b0, w1_ff}));
   end

   // round to nearest, ties away from zero, clamp, then saturating add
   always_comb begin
      bias = prod_ff[48] ? 49'sd16383 : 49'sd16384;
      rnd  = prod_ff + bias;
      part = $signed(rnd[48:15]);
      if (part > P_MAX) begin
         part32 = 32'sh7fffffff;
      end else if (part < P_MIN) begin
         part32 = 32'sh80000000;
      end else begin
         part32 = part[31:0];
      end
      sum = $signed({blend_ff[31], blend_ff}) + $signed({part32[31], part32});
      blend_in = blend_ff;
      if (ctl.clear) begin
         blend_in = '0;
      end else if (pv_ff) begin
         if (sum[32] != sum[31]) begin
            blend_in = sum[32] ? 32'sh80000000 : 32'sh7fffffff;
         end else begin
            blend_in = sum[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff  <= 1'b0;
         pv_ff    <= 1'b0;
         blend_ff <= '0;
      end else begin
         rd_v_ff  <= ctl.rd_en;
         pv_ff    <= rd_v_ff;
         blend_ff <= blend_in;
      end
   end

   assign blend = blend_ff;

endmodule
`default_nettype wire

// ===== hdl/lbs_mac.sv =====
`default_nettype none
module lbs_mac (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire lbs_pkg::mac_op_type        op,
   output lbs_pkg::mac_done_type           done,
   output logic signed [lbs_pkg::ACC_W-1:0] acc
);

   localparam int AW = lbs_pkg::ACC_W;

   logic signed [65:0] prod_ff, prod_in;
   logic               v1_ff, hi1_ff, neg1_ff, first1_ff, last1_ff;
   lbs_pkg::dest_type  dest1_ff;
   logic [3:0]         idx1_ff;

   logic signed [AW-1:0] term, acc_ff, acc_in;
   lbs_pkg::mac_done_type done_ff, done_in;

   always_comb begin
      prod_in = 66'($signed(op.a) * $signed(op.b));
   end

   always_comb begin
      term = $signed({{(AW-66){prod_ff[65]}}, prod_ff});
      if (hi1_ff) begin
         term = term <<< 32;
      end
      if (neg1_ff) begin
         term = -term;
      end
      acc_in = acc_ff;
      if (v1_ff) begin
         acc_in = (first1_ff ? '0 : acc_ff) + term;
      end
      done_in.valid = v1_ff & last1_ff;
      done_in.dest  = dest1_ff;
      done_in.idx   = idx1_ff;
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      hi1_ff    <= op.shift_hi;
      neg1_ff   <= op.neg;
      first1_ff <= op.first;
      last1_ff  <= op.last;
      dest1_ff  <= op.dest;
      idx1_ff   <= op.idx;
      acc_ff    <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         done_ff <= '0;
      end else begin
         v1_ff   <= op.valid;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign acc  = acc_ff;

endmodule
`default_nettype wire

// ===== hdl/lbs_div.sv =====
`default_nettype none
module lbs_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic signed [lbs_pkg::NUM_W-1:0]  num,
   input  wire logic signed [lbs_pkg::ACC_W-1:0]  den,
   output logic                                   done,
   output logic signed [31:0]                     quo
);

   localparam int NW = lbs_pkg::NUM_W;
   localparam int AW = lbs_pkg::ACC_W;
   localparam int DW = lbs_pkg::DS_W;

   lbs_pkg::div_state_type state_ff, state_in;

   logic [NW-1:0] n_ff, n_in;
   logic [AW-1:0] d_ff, d_in;
   logic [DW-1:0] ds_ff, ds_in;
   logic [33:0]   q_ff, q_in;
   logic [5:0]    step_ff, step_in;
   logic          neg_ff, neg_in;
   logic          done_ff, done_in;
   logic signed [31:0] quo_ff, quo_in;

   logic          ge, ovf, up;
   logic [33:0]   qr, qs, limit;

   always_comb begin
      ovf = {{(DW-NW){1'b0}}, n_ff} >= {d_ff, 33'b0};
      ge  = {{(DW-NW){1'b0}}, n_ff} >= ds_ff;
      up  = {n_ff, 1'b0} >= {{(NW+1-AW){1'b0}}, d_ff};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lbs_pkg::DV_IDLE:  if (start) state_in = lbs_pkg::DV_CHECK;
         lbs_pkg::DV_CHECK: state_in = ovf ? lbs_pkg::DV_ROUND : lbs_pkg::DV_RUN;
         lbs_pkg::DV_RUN:   if (step_ff == '0) state_in = lbs_pkg::DV_ROUND;
         lbs_pkg::DV_ROUND: state_in = lbs_pkg::DV_IDLE;
         default:           state_in = lbs_pkg::DV_IDLE;
      endcase
   end

   always_comb begin
      n_in    = n_ff;
      d_in    = d_ff;
      ds_in   = ds_ff;
      q_in    = q_ff;
      step_in = step_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      limit   = neg_ff ? 34'h080000000 : 34'h07fffffff;
      qr      = q_ff + {33'b0, up};
      qs      = (qr > limit) ? limit : qr;
      unique case (state_ff)
         lbs_pkg::DV_IDLE: begin
            if (start) begin
               n_in   = num[NW-1] ? NW'(-num) : NW'(num);
               d_in   = den[AW-1] ? AW'(-den) : AW'(den);
               neg_in = num[NW-1] ^ den[AW-1];
            end
         end
         lbs_pkg::DV_CHECK: begin
            q_in    = '0;
            ds_in   = {1'b0, d_ff, 32'b0};
            step_in = 6'd32;
            if (ovf) begin
               q_in = '1;
               n_in = '0;
            end
         end
         lbs_pkg::DV_RUN: begin
            if (ge) begin
               n_in = n_ff - ds_ff[NW-1:0];
            end
            q_in    = {q_ff[32:0], ge};
            ds_in   = ds_ff >> 1;
            step_in = step_ff - 6'd1;
         end
         lbs_pkg::DV_ROUND: begin
            done_in = 1'b1;
            quo_in  = neg_ff ? $signed(-qs[31:0]) : $signed(qs[31:0]);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      d_ff    <= d_in;
      ds_ff   <= ds_in;
      q_ff    <= q_in;
      step_ff <= step_in;
      neg_ff  <= neg_in;
      quo_ff  <= quo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lbs_pkg::DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule
`default_nettype wire

// ===== hdl/linear_blend_vertex_skinning_unit.sv =====
`default_nettype none
// Linear blend skinning engine, one item at a time. An influence item steps
// through its INFL influences: twelve lanes, one per matrix element, each with
// its own joint-store bank, read one joint per cycle and multiply-accumulate
// into the blended matrix, then drain. A position item runs twelve products on
// the shared 33x33 multiply-accumulate unit, then a pipeline drain. A direction
// item runs 42 multiply-accumulate steps for cofactors, determinant and
// numerators, then, unless the determinant is zero, three divisions on the
// bit-serial divider. A finished result waits in the output register while the
// next item is taken. The joint store has no reset; read only joints you loaded.
module linear_blend_vertex_skinning_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_op,
   input  wire logic [9:0]         req_matrix_addr,
   input  wire logic signed [31:0] req_comp_x,
   input  wire logic signed [31:0] req_comp_y,
   input  wire logic signed [31:0] req_comp_z,
   input  wire logic [31:0]        req_joint_ids,
   input  wire logic [15:0]        req_weight_a,
   input  wire logic [15:0]        req_weight_b,
   input  wire logic [15:0]        req_weight_c,
   input  wire logic [15:0]        req_weight_d,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_out_x,
   output logic signed [31:0]      rsp_out_y,
   output logic signed [31:0]      rsp_out_z,
   output logic                    rsp_degenerate
);

   localparam int AW    = lbs_pkg::ACC_W;
   localparam int WORDS = lbs_pkg::WORDS;
   localparam int INFL  = lbs_pkg::INFL;
   localparam int INFL_IDX_W = lbs_pkg::INFL_W;

   lbs_pkg::state_type state_ff, state_in;
   logic [1:0] row_ff, row_in;
   logic [3:0] sub_ff, sub_in;
   logic       ph_ff, ph_in;

   logic accept;

   logic               is_dir_ff, is_dir_in;
   logic signed [31:0] vec_ff [lbs_pkg::ROWS];
   logic signed [31:0] vec_in [lbs_pkg::ROWS];
   logic [7:0]         jid_ff [INFL];
   logic [7:0]         jid_in [INFL];
   logic [15:0]        wgt_ff [INFL];
   logic [15:0]        wgt_in [INFL];
   logic [7:0]         jid_all [4];
   logic [15:0]        wgt_all [4];

   logic signed [31:0] blend [WORDS];

   logic signed [64:0]   cof_ff [lbs_pkg::COFS];
   logic signed [64:0]   cof_in [lbs_pkg::COFS];
   logic signed [AW-1:0] det_ff, det_in;
   logic signed [AW-1:0] num_ff [lbs_pkg::ROWS];
   logic signed [AW-1:0] num_in [lbs_pkg::ROWS];
   logic signed [31:0]   res_ff [lbs_pkg::ROWS];
   logic signed [31:0]   res_in [lbs_pkg::ROWS];
   logic                 deg_ff, deg_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;
   logic               rsp_deg_ff, rsp_deg_in;

   lbs_pkg::lane_ctl_type lane_ctl;
   logic [WORDS-1:0]      lane_we;
   lbs_pkg::mac_op_type   mac_op;
   lbs_pkg::mac_done_type mac_done;
   logic signed [AW-1:0]  mac_acc;
   logic                  div_start, div_done;
   logic signed [31:0]    div_quo;

   logic [20:0] addr_prod;
   logic [7:0]  ld_joint;
   logic [9:0]  ld_elem;
   logic        ld_ok;
   logic        out_free;
   logic [INFL_IDX_W-1:0] kidx;
   logic [7:0]  cur_jid;
   logic [3:0]  cof_idx;
   logic [1:0]  tm1;

   assign accept   = req_valid & req_ready;
   assign out_free = ~rsp_valid_ff | rsp_ready;

   assign jid_all[0] = req_joint_ids[7:0];
   assign jid_all[1] = req_joint_ids[15:8];
   assign jid_all[2] = req_joint_ids[23:16];
   assign jid_all[3] = req_joint_ids[31:24];
   assign wgt_all[0] = req_weight_a;
   assign wgt_all[1] = req_weight_b;
   assign wgt_all[2] = req_weight_c;
   assign wgt_all[3] = req_weight_d;

   // matrix address -> joint, element
   always_comb begin
      addr_prod = {11'b0, req_matrix_addr} * 21'(lbs_pkg::RECIP12);
      ld_joint  = addr_prod[lbs_pkg::RECIP_SH+7:lbs_pkg::RECIP_SH];
      ld_elem   = req_matrix_addr - 10'({2'b0, ld_joint} * 10'(WORDS));
      ld_ok     = {2'b0, req_matrix_addr} < 12'(lbs_pkg::STORE_DEPTH);
   end

   assign kidx    = sub_ff[INFL_IDX_W-1:0];
   assign cur_jid = jid_ff[kidx];
   assign cof_idx = ({2'b0, row_ff} << 1) + {2'b0, row_ff} + sub_ff;
   assign tm1     = sub_ff[1:0] - 2'd1;

   function automatic logic signed [31:0] round_q16(input logic signed [AW-1:0] a);
      logic signed [AW-1:0] bias, t, s, smax, smin;
      bias = a[AW-1] ? AW'(32767) : AW'(32768);
      t    = a + bias;
      s    = t >>> 16;
      smax = AW'(32'h7fffffff);
      smin = ~smax;
      if (s > smax) begin
         return 32'sh7fffffff;
      end else if (s < smin) begin
         return 32'sh80000000;
      end
      return s[31:0];
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      sub_in   = sub_ff;
      ph_in    = ph_ff;
      unique case (state_ff)
         lbs_pkg::ST_IDLE: begin
            row_in = '0;
            sub_in = '0;
            ph_in  = 1'b0;
            if (accept) begin
               unique case (req_op)
                  lbs_pkg::OP_START, lbs_pkg::OP_ADD: state_in = lbs_pkg::ST_INF;
                  lbs_pkg::OP_POS:                    state_in = lbs_pkg::ST_POS;
                  lbs_pkg::OP_DIR:                    state_in = lbs_pkg::ST_COF;
                  default:                            state_in = lbs_pkg::ST_IDLE;
               endcase
            end
         end
         lbs_pkg::ST_INF: begin
            if (sub_ff == 4'(INFL - 1)) begin
               state_in = lbs_pkg::ST_INF_WAIT;
               sub_in   = '0;
            end else begin
               sub_in = sub_ff + 4'd1;
            end
         end
         lbs_pkg::ST_INF_WAIT: begin
            if (sub_ff == 4'(lbs_pkg::LANE_DRAIN - 1)) begin
               state_in = lbs_pkg::ST_IDLE;
            end else begin
               sub_in = sub_ff + 4'd1;
            end
         end
         lbs_pkg::ST_POS: begin
            if (sub_ff == 4'(lbs_pkg::POS_TERMS - 1)) begin
               sub_in = '0;
               if (row_ff == 2'(lbs_pkg::ROWS - 1)) begin
                  state_in = lbs_pkg::ST_DRAIN;
               end else begin
                  row_in = row_ff + 2'd1;
               end
            end else begin
               sub_in = sub_ff + 4'd1;
            end
         end
         lbs_pkg::ST_COF: begin
            ph_in = ~ph_ff;
            if (ph_ff) begin
               if (sub_ff == 4'(lbs_pkg::COFS - 1)) begin
                  state_in = lbs_pkg::ST_DET;
                  sub_in   = '0;
               end else begin
                  sub_in = sub_ff + 4'd1;
               end
            end
         end
         lbs_pkg::ST_DET: begin
            ph_in = ~ph_ff;
            if (ph_ff) begin
               if (sub_ff == 4'(lbs_pkg::ROWS - 1)) begin
                  state_in = lbs_pkg::ST_NUM;
                  sub_in   = '0;
                  row_in   = '0;
               end else begin
                  sub_in = sub_ff + 4'd1;
               end
            end
         end
         lbs_pkg::ST_NUM: begin
            ph_in = ~ph_ff;
            if (ph_ff) begin
               if (sub_ff == 4'(lbs_pkg::ROWS - 1)) begin
                  sub_in = '0;
                  if (row_ff == 2'(lbs_pkg::ROWS - 1)) begin
                     state_in = lbs_pkg::ST_DRAIN;
                  end else begin
                     row_in = row_ff + 2'd1;
                  end
               end else begin
                  sub_in = sub_ff + 4'd1;
               end
            end
         end
         lbs_pkg::ST_DRAIN: begin
            if (sub_ff == 4'(lbs_pkg::MAC_DRAIN - 1)) begin
               state_in = is_dir_ff ? lbs_pkg::ST_CHECK : lbs_pkg::ST_OUT;
               sub_in   = '0;
            end else begin
               sub_in = sub_ff + 4'd1;
            end
         end
         lbs_pkg::ST_CHECK: begin
            row_in   = '0;
            state_in = (det_ff == '0) ? lbs_pkg::ST_OUT : lbs_pkg::ST_DIV;
         end
         lbs_pkg::ST_DIV: state_in = lbs_pkg::ST_DIV_WAIT;
         lbs_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               if (row_ff == 2'(lbs_pkg::ROWS - 1)) begin
                  state_in = lbs_pkg::ST_OUT;
               end else begin
                  row_in   = row_ff + 2'd1;
                  state_in = lbs_pkg::ST_DIV;
               end
            end
         end
         lbs_pkg::ST_OUT: if (out_free) state_in = lbs_pkg::ST_IDLE;
         default: state_in = lbs_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready        = (state_ff == lbs_pkg::ST_IDLE);
      lane_ctl.clear   = 1'b0;
      lane_ctl.wr_addr = ld_joint[lbs_pkg::JOINT_AW-1:0];
      lane_ctl.wr_data = req_comp_x;
      lane_ctl.rd_en   = 1'b0;
      lane_ctl.rd_addr = cur_jid[lbs_pkg::JOINT_AW-1:0];
      lane_ctl.weight  = wgt_ff[kidx];
      lane_we          = '0;
      mac_op           = '0;
      div_start        = 1'b0;
      unique case (state_ff)
         lbs_pkg::ST_IDLE: begin
            if (accept && req_op == lbs_pkg::OP_LOAD && ld_ok) begin
               for (int e = 0; e < WORDS; e++) begin
                  lane_we[e] = (ld_elem[3:0] == 4'(e));
               end
            end
            lane_ctl.clear = accept && req_op == lbs_pkg::OP_START;
         end
         lbs_pkg::ST_INF: begin
            lane_ctl.rd_en = {1'b0, cur_jid} < 9'(lbs_pkg::JOINTS);
         end
         lbs_pkg::ST_POS: begin
            mac_op.valid = 1'b1;
            mac_op.first = (sub_ff == '0);
            mac_op.last  = (sub_ff == 4'(lbs_pkg::POS_TERMS - 1));
            mac_op.dest  = lbs_pkg::DST_POS;
            mac_op.idx   = {2'b0, row_ff};
            if (sub_ff == '0) begin
               mac_op.a = 33'(blend[{row_ff, 2'b11}]);
               mac_op.b = 33'sd65536;
            end else begin
               mac_op.a = 33'(blend[{row_ff, tm1}]);
               mac_op.b = 33'(vec_ff[tm1]);
            end
         end
         lbs_pkg::ST_COF: begin
            mac_op.valid = 1'b1;
            mac_op.first = ~ph_ff;
            mac_op.last  = ph_ff;
            mac_op.neg   = ph_ff;
            mac_op.dest  = lbs_pkg::DST_COF;
            mac_op.idx   = sub_ff;
            mac_op.a     = 33'(blend[lbs_pkg::COF_TAB[sub_ff][{ph_ff, 1'b0}]]);
            mac_op.b     = 33'(blend[lbs_pkg::COF_TAB[sub_ff][{ph_ff, 1'b1}]]);
         end
         lbs_pkg::ST_DET: begin
            mac_op.valid    = 1'b1;
            mac_op.first    = (sub_ff == '0) && !ph_ff;
            mac_op.last     = (sub_ff == 4'(lbs_pkg::ROWS - 1)) && ph_ff;
            mac_op.shift_hi = ph_ff;
            mac_op.dest     = lbs_pkg::DST_DET;
            mac_op.a        = ph_ff ? cof_ff[sub_ff][64:32]
                                    : $signed({1'b0, cof_ff[sub_ff][31:0]});
            mac_op.b        = 33'(blend[sub_ff]);
         end
         lbs_pkg::ST_NUM: begin
            mac_op.valid    = 1'b1;
            mac_op.first    = (sub_ff == '0) && !ph_ff;
            mac_op.last     = (sub_ff == 4'(lbs_pkg::ROWS - 1)) && ph_ff;
            mac_op.shift_hi = ph_ff;
            mac_op.dest     = lbs_pkg::DST_NUM;
            mac_op.idx      = {2'b0, row_ff};
            mac_op.a        = ph_ff ? cof_ff[cof_idx][64:32]
                                    : $signed({1'b0, cof_ff[cof_idx][31:0]});
            mac_op.b        = 33'(vec_ff[sub_ff[1:0]]);
         end
         lbs_pkg::ST_DIV: div_start = 1'b1;
         default: ;
      endcase
   end

   // datapath registers
   always_comb begin
      is_dir_in = is_dir_ff;
      vec_in    = vec_ff;
      jid_in    = jid_ff;
      wgt_in    = wgt_ff;
      cof_in    = cof_ff;
      det_in    = det_ff;
      num_in    = num_ff;
      res_in    = res_ff;
      deg_in    = deg_ff;
      rsp_x_in  = rsp_x_ff;
      rsp_y_in  = rsp_y_ff;
      rsp_z_in  = rsp_z_ff;
      rsp_deg_in   = rsp_deg_ff;
      rsp_valid_in = rsp_valid_ff;

      if (accept) begin
         is_dir_in = (req_op == lbs_pkg::OP_DIR);
         deg_in    = 1'b0;
         vec_in[0] = req_comp_x;
         vec_in[1] = req_comp_y;
         vec_in[2] = req_comp_z;
         for (int k = 0; k < INFL; k++) begin
            jid_in[k] = jid_all[k];
            wgt_in[k] = wgt_all[k];
         end
      end

      if (mac_done.valid) begin
         unique case (mac_done.dest)
            lbs_pkg::DST_COF: cof_in[mac_done.idx] = mac_acc[64:0];
            lbs_pkg::DST_DET: det_in = mac_acc;
            lbs_pkg::DST_NUM: num_in[mac_done.idx[1:0]] = mac_acc;
            lbs_pkg::DST_POS: res_in[mac_done.idx[1:0]] = round_q16(mac_acc);
            default: ;
         endcase
      end

      if (state_ff == lbs_pkg::ST_CHECK && det_ff == '0) begin
         deg_in = 1'b1;
         for (int i = 0; i < lbs_pkg::ROWS; i++) begin
            res_in[i] = '0;
         end
      end

      if (state_ff == lbs_pkg::ST_DIV_WAIT && div_done) begin
         res_in[row_ff] = div_quo;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == lbs_pkg::ST_OUT && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = res_ff[0];
         rsp_y_in     = res_ff[1];
         rsp_z_in     = res_ff[2];
         rsp_deg_in   = deg_ff;
      end
   end

   always_ff @(posedge clock) begin
      is_dir_ff  <= is_dir_in;
      vec_ff     <= vec_in;
      jid_ff     <= jid_in;
      wgt_ff     <= wgt_in;
      cof_ff     <= cof_in;
      det_ff     <= det_in;
      num_ff     <= num_in;
      res_ff     <= res_in;
      deg_ff     <= deg_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_z_ff   <= rsp_z_in;
      rsp_deg_ff <= rsp_deg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lbs_pkg::ST_IDLE;
         row_ff       <= '0;
         sub_ff       <= '0;
         ph_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         sub_ff       <= sub_in;
         ph_ff        <= ph_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   for (genvar e = 0; e < WORDS; e++) begin : g_lane
      lbs_lane u_lane (
         .clock (clock),
         .reset (reset),
         .ctl   (lane_ctl),
         .we    (lane_we[e]),
         .blend (blend[e])
      );
   end

   lbs_mac u_mac (
      .clock (clock),
      .reset (reset),
      .op    (mac_op),
      .done  (mac_done),
      .acc   (mac_acc)
   );

   lbs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ({num_ff[row_ff], 16'b0}),
      .den   (det_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_x      = rsp_x_ff;
   assign rsp_out_y      = rsp_y_ff;
   assign rsp_out_z      = rsp_z_ff;
   assign rsp_degenerate = rsp_deg_ff;

endmodule
`default_nettype wire

// ===== dv/lbs_checker.sv =====
`default_nettype none
module lbs_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic [2:0]         req_op,
   input  wire logic [9:0]         req_matrix_addr,
   input  wire logic signed [31:0] req_comp_x,
   input  wire logic signed [31:0] req_comp_y,
   input  wire logic signed [31:0] req_comp_z,
   input  wire logic [31:0]        req_joint_ids,
   input  wire logic [15:0]        req_weight_a,
   input  wire logic [15:0]        req_weight_b,
   input  wire logic [15:0]        req_weight_c,
   input  wire logic [15:0]        req_weight_d,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic signed [31:0] rsp_out_x,
   input  wire logic signed [31:0] rsp_out_y,
   input  wire logic signed [31:0] rsp_out_z,
   input  wire logic               rsp_degenerate,
   output int                      fail_count,
   output int                      pending
);

   typedef logic signed [159:0] wide_type;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               degenerate;
   } vertex_out_type;

   logic [31:0]        joint_words [lbs_pkg::STORE_DEPTH];
   logic signed [31:0] blend [lbs_pkg::WORDS];
   vertex_out_type     expected_q [$];

   function automatic wide_type widen(input logic signed [63:0] v);
      return v;
   endfunction

   // round(num/den), ties away from zero, clamped to 32-bit signed
   function automatic logic signed [31:0] div_round_sat(input wide_type num,
                                                        input wide_type den);
      logic     neg;
      wide_type n, d, q, r, lim;
      neg = num[159] ^ den[159];
      n   = num[159] ? -num : num;
      d   = den[159] ? -den : den;
      q   = n / d;
      r   = n % d;
      if (r + r >= d) q = q + 1;
      lim = neg ? widen(64'sh80000000) : widen(64'sh7fffffff);
      if (q > lim) q = lim;
      q = neg ? -q : q;
      return q[31:0];
   endfunction

   function automatic wide_type el(input int r, input int c);
      return widen(blend[r*4+c]);
   endfunction

   function automatic void blend_influences(input logic [31:0] ids, input logic [15:0] wt [4]);
      logic [7:0]         joint;
      logic signed [63:0] part, sum;
      for (int k = 0; k < lbs_pkg::INFL; k++) begin
         joint = ids[8*k +: 8];
         if (joint < lbs_pkg::JOINTS) begin
            for (int e = 0; e < lbs_pkg::WORDS; e++) begin
               part = div_round_sat(widen(signed'(joint_words[joint*lbs_pkg::WORDS+e])) *
                                    widen({48'b0, wt[k]}), widen(32768));
               sum = widen(blend[e]) + part;
               if (sum > 64'sh7fffffff) sum = 64'sh7fffffff;
               if (sum < -64'sh80000000) sum = -64'sh80000000;
               blend[e] = sum[31:0];
            end
         end
      end
   endfunction

   function automatic void skin_vertex(input lbs_pkg::op_type op,
                                       input logic signed [31:0] v [3]);
      vertex_out_type res;
      wide_type       acc, det, num;
      wide_type       cof [3][3];
      int             i1, i2, j1, j2;
      res = '{0, 0, 0, 1'b0};
      if (op == lbs_pkg::OP_POS) begin
         for (int i = 0; i < 3; i++) begin
            acc = el(i, 3) * widen(lbs_pkg::Q16_ONE);
            for (int j = 0; j < 3; j++) acc = acc + el(i, j) * widen(v[j]);
            if (i == 0) res.x = div_round_sat(acc, widen(lbs_pkg::Q16_ONE));
            if (i == 1) res.y = div_round_sat(acc, widen(lbs_pkg::Q16_ONE));
            if (i == 2) res.z = div_round_sat(acc, widen(lbs_pkg::Q16_ONE));
         end
      end else begin
         for (int i = 0; i < 3; i++) begin
            i1 = (i + 1) % 3;
            i2 = (i + 2) % 3;
            for (int j = 0; j < 3; j++) begin
               j1 = (j + 1) % 3;
               j2 = (j + 2) % 3;
               cof[i][j] = el(i1, j1) * el(i2, j2) - el(i1, j2) * el(i2, j1);
            end
         end
         det = '0;
         for (int j = 0; j < 3; j++) det = det + el(0, j) * cof[0][j];
         if (det == 0) begin
            res.degenerate = 1'b1;
         end else begin
            for (int i = 0; i < 3; i++) begin
               num = '0;
               for (int j = 0; j < 3; j++) num = num + cof[i][j] * widen(v[j]);
               num = num * widen(lbs_pkg::Q16_ONE);
               if (i == 0) res.x = div_round_sat(num, det);
               if (i == 1) res.y = div_round_sat(num, det);
               if (i == 2) res.z = div_round_sat(num, det);
            end
         end
      end
      expected_q = {expected_q, res};
   endfunction

   always @(posedge clock) begin
      logic [15:0]        wt [4];
      logic signed [31:0] v [3];
      vertex_out_type     exp_out;
      if (reset) begin
         foreach (blend[i]) blend[i] = '0;
         foreach (joint_words[i]) joint_words[i] = '0;
         expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("result with no item pending");
               fail_count++;
            end else begin
               exp_out = expected_q.pop_front();
               if (rsp_out_x !== exp_out.x) begin
                  $error("out_x expected %0d got %0d", exp_out.x, rsp_out_x);
                  fail_count++;
               end
               if (rsp_out_y !== exp_out.y) begin
                  $error("out_y expected %0d got %0d", exp_out.y, rsp_out_y);
                  fail_count++;
               end
               if (rsp_out_z !== exp_out.z) begin
                  $error("out_z expected %0d got %0d", exp_out.z, rsp_out_z);
                  fail_count++;
               end
               if (rsp_degenerate !== exp_out.degenerate) begin
                  $error("degenerate expected %0b got %0b", exp_out.degenerate,
                         rsp_degenerate);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            wt = '{req_weight_a, req_weight_b, req_weight_c, req_weight_d};
            v  = '{req_comp_x, req_comp_y, req_comp_z};
            unique case (req_op)
               lbs_pkg::OP_LOAD: if (req_matrix_addr < lbs_pkg::STORE_DEPTH)
                  joint_words[req_matrix_addr] = req_comp_x;
               lbs_pkg::OP_START: begin
                  foreach (blend[i]) blend[i] = '0;
                  blend_influences(req_joint_ids, wt);
               end
               lbs_pkg::OP_ADD: blend_influences(req_joint_ids, wt);
               lbs_pkg::OP_POS: skin_vertex(lbs_pkg::OP_POS, v);
               lbs_pkg::OP_DIR: skin_vertex(lbs_pkg::OP_DIR, v);
               default: ;
            endcase
         end
      end
      pending <= expected_q.size();
   end

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none
module tb;

   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      logic [2:0]         op;
      logic [9:0]         addr;
      logic signed [31:0] x, y, z;
      logic [31:0]        ids;
      logic [15:0]        wa, wb, wc, wd;
   } skin_req_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_op = '0;
   logic [9:0]         req_matrix_addr = '0;
   logic signed [31:0] req_comp_x = '0, req_comp_y = '0, req_comp_z = '0;
   logic [31:0]        req_joint_ids = '0;
   logic [15:0]        req_weight_a = '0, req_weight_b = '0;
   logic [15:0]        req_weight_c = '0, req_weight_d = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic               rsp_degenerate;
   int                 fail_count, pending;
   int                 cycles = 0;
   logic               calm = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   linear_blend_vertex_skinning_unit dut (.*);

   lbs_checker u_checker (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // calm stretches: no gaps on either side
   always @(posedge clock) if ($urandom_range(0, 299) == 0) calm <= ~calm;

   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm && $urandom_range(0, 99) < 25)
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                      : $urandom_range(1, 3);
      end
   end

   task automatic send(input skin_req_type it);
      int gap;
      req_valid       <= 1'b1;
      req_op          <= it.op;
      req_matrix_addr <= it.addr;
      req_comp_x      <= it.x;
      req_comp_y      <= it.y;
      req_comp_z      <= it.z;
      req_joint_ids   <= it.ids;
      req_weight_a    <= it.wa;
      req_weight_b    <= it.wb;
      req_weight_c    <= it.wc;
      req_weight_d    <= it.wd;
      do @(posedge clock); while (!req_ready);
      gap = 0;
      if (!calm) begin
         case ($urandom_range(0, 9))
            0, 1, 2:  gap = $urandom_range(1, 3);
            3:        gap = $urandom_range(8, 40);
            default:  gap = 0;
         endcase
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending and wait until every expected result has come
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      @(posedge clock);
   endtask

   function automatic skin_req_type blank(input lbs_pkg::op_type op);
      skin_req_type it;
      it = '{op: op, addr: '0, x: '0, y: '0, z: '0, ids: '0,
             wa: '0, wb: '0, wc: '0, wd: '0};
      return it;
   endfunction

   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(0, 9))
         0:       return $urandom;
         1, 2:    return 32'sd65536 + $signed($urandom_range(0, 8191)) - 4096;
         default: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      endcase
   endfunction

   function automatic logic signed [31:0] rand_comp();
      if ($urandom_range(0, 7) == 0) return $urandom;
      return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
   endfunction

   task automatic load(input int joint, input int e, input logic signed [31:0] val);
      skin_req_type it;
      it      = blank(lbs_pkg::OP_LOAD);
      it.addr = 10'(joint * lbs_pkg::WORDS + e);
      it.x    = val;
      send(it);
   endtask

   function automatic skin_req_type influence(input lbs_pkg::op_type op, input logic wild);
      skin_req_type it;
      int           left;
      it = blank(op);
      for (int k = 0; k < 4; k++)
         it.ids[8*k +: 8] = 8'(wild ? $urandom_range(0, 255)
                                    : $urandom_range(0, lbs_pkg::JOINTS - 1));
      if (wild) begin
         it.wa = 16'($urandom); it.wb = 16'($urandom);
         it.wc = 16'($urandom); it.wd = 16'($urandom);
      end else begin
         left  = 32768;
         it.wa = 16'($urandom_range(0, left)); left -= it.wa;
         it.wb = 16'($urandom_range(0, left)); left -= it.wb;
         it.wc = 16'($urandom_range(0, left)); left -= it.wc;
         it.wd = 16'(left);
      end
      return it;
   endfunction

   function automatic skin_req_type vertex(input lbs_pkg::op_type op);
      skin_req_type it;
      it   = blank(op);
      it.x = rand_comp();
      it.y = rand_comp();
      it.z = rand_comp();
      return it;
   endfunction

   initial begin
      skin_req_type it;
      int           sent, n, next_drain;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // joint 0 identity with translation, joint 1 zero, rest random
      for (int j = 0; j < lbs_pkg::JOINTS; j++)
         for (int e = 0; e < lbs_pkg::WORDS; e++) begin
            if (j == 0) load(j, e, (e % 5 == 0) ? 32'sd65536 : (e % 4 == 3) ? 32'sd131072 : 0);
            else if (j == 1) load(j, e, 0);
            else load(j, e, rand_word());
         end

      // directed
      it = blank(lbs_pkg::OP_START); it.ids = 32'hffff_0100; it.wa = 16'd32768; send(it);
      it = blank(lbs_pkg::OP_POS); it.x = 32'sh7fffffff; it.y = 32'sh80000000; it.z = 1;
      send(it);
      it = blank(lbs_pkg::OP_DIR); it.x = 32'sh7fffffff; it.y = 32'sh80000000; it.z = -1;
      send(it);
      it = blank(lbs_pkg::OP_ADD); it.ids = 32'h0000_4000; it.wa = 16'hffff; send(it);
      it = blank(lbs_pkg::OP_POS); it.x = 65536; it.y = -65536; it.z = 0; send(it);
      it = blank(lbs_pkg::OP_START); it.ids = 32'h0101_0101; it.wa = 16'hffff;
      it.wb = 16'hffff; it.wc = 16'hffff; it.wd = 16'hffff; send(it);
      it = blank(lbs_pkg::OP_DIR); it.x = 65536; it.y = 65536; it.z = 65536; send(it);
      it = blank(lbs_pkg::OP_START); it.ids = 32'h0000_0000; send(it);
      it = blank(lbs_pkg::OP_DIR); it.x = 12345; send(it);
      it = blank(lbs_pkg::OP_POS); it.x = 32'sh7fffffff; send(it);
      it = blank(lbs_pkg::OP_LOAD); it.addr = 10'h3ff; it.x = 32'hffff_ffff; send(it);
      it = blank(lbs_pkg::OP_LOAD); it.addr = 10'(lbs_pkg::STORE_DEPTH);
      it.x = 32'h1234_5678; send(it);
      for (int op = 5; op < 8; op++) begin
         it = blank(lbs_pkg::OP_LOAD); it.op = 3'(op); it.x = $urandom;
         it.ids = 32'hffff_ffff; send(it);
      end
      it = blank(lbs_pkg::OP_START); it.ids = 32'h0302_0100; it.wa = 16'd16384;
      it.wb = 16'd16384; it.wc = 16'hffff; it.wd = 16'h8000; send(it);
      it = blank(lbs_pkg::OP_DIR); it.x = -65536; it.y = 32768; it.z = -1; send(it);
      it = blank(lbs_pkg::OP_POS); it.x = 32'sh80000000; it.y = 32'sh80000000;
      it.z = 32'sh80000000; send(it);

      // random: mostly well-formed vertices, some noise
      sent       = 0;
      next_drain = 300;
      while (sent < 860) begin
         if (sent >= next_drain) begin
            drain();
            next_drain += 300;
         end
         case ($urandom_range(0, 19))
            0: begin
               it = blank(lbs_pkg::OP_LOAD);
               it.addr = 10'(($urandom_range(0, 3) == 0)
                             ? $urandom_range(0, 1023)
                             : $urandom_range(2 * lbs_pkg::WORDS, lbs_pkg::STORE_DEPTH - 1));
               it.x = rand_word();
               send(it); sent++;
            end
            1: begin
               it = vertex(lbs_pkg::OP_POS); it.op = 3'($urandom_range(5, 7));
               it.ids = $urandom; it.addr = 10'($urandom); send(it); sent++;
            end
            default: begin
               send(influence(lbs_pkg::OP_START, $urandom_range(0, 5) == 0)); sent++;
               n = $urandom_range(0, 2);
               repeat (n) begin
                  send(influence(lbs_pkg::OP_ADD, $urandom_range(0, 5) == 0)); sent++;
               end
               n = $urandom_range(1, 4);
               repeat (n) begin
                  send(vertex($urandom_range(0, 1) ? lbs_pkg::OP_POS : lbs_pkg::OP_DIR));
                  sent++;
               end
            end
         endcase
      end

      drain();
      repeat (300) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire
